// File: rtl/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared types and codes for the first-fit section allocator.
// ----------------------------------------------------------------------------
package ffac_pkg;

	localparam int ID_W   = 16;
	localparam int SIZE_W = 17;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,       // latch request, clear scan index
		CMD_SCAN_STEP,  // advance scan index
		CMD_SORT_STEP,  // one compare/swap of the sort
		CMD_PACK_STEP,  // place one used entry
		CMD_PACK_DONE,  // write new free entry 0
		CMD_ALLOC,      // perform allocation at found index
		CMD_FREE,       // move used entry to free table
		CMD_SHIFT_FREE, // one shift step in free table
		CMD_SHIFT_USED  // one shift step in used table
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic clr_idx;
	} ctl_t;

	typedef struct packed {
		logic free_empty;
		logic free_full;
		logic used_full;
		logic size_ok;
		logic scan_end;   // scan index reached end of table
		logic hit;        // entry at scan index matches
		logic exact;      // found free entry is an exact fit
		logic sort_end;
		logic pack_end;   // every used entry placed
		logic shift_end;
	} sts_t;

endpackage

// File: rtl/first_fit_allocator_with_compaction_unit.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit
// First-fit section allocator with compaction on a failed fit.
// ----------------------------------------------------------------------------
// channel   direction  signals
// request   in         in_valid/in_ready, req_type, alloc_size, free_id
// response  out        out_valid/out_ready, status, section_id
// config    in         cfg_we, cfg_wdata (mem_size)
//
// a request scans a section table; a free adds a used-table shift, an exact
// allocation a free-table shift
// a compaction adds a bubble sort of the used table and a pack pass
// the sequencer handles one request at a time; the next is taken once the
// response register is free and the sequencer is back to idle
// reset gives one free section of 4096 bytes at address zero
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit #(
	parameter int MAX_SECTIONS = 16,
	parameter int ADDR_BITS    = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [ffac_pkg::SIZE_W-1:0]  alloc_size,
	input  logic [ffac_pkg::ID_W-1:0]    free_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ffac_pkg::STAT_W-1:0]  status,
	output logic [ffac_pkg::ID_W-1:0]    section_id,
	input  logic                         cfg_we,
	input  logic [ffac_pkg::SIZE_W-1:0]  cfg_wdata
);
	import ffac_pkg::*;

	logic [SIZE_W-1:0] mem_size_q;
	ctl_t ctl;
	sts_t sts;
	logic idle, in_fire, type_q;
	logic [ID_W-1:0] nid;

	// mem_size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mem_size_q <= SIZE_W'(4096);
		else if (cfg_we) mem_size_q <= cfg_wdata;
	end

	// one request in flight; response must be drained first
	assign in_ready = idle && !out_valid;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire) type_q <= req_type;
	end

	ffac_datapath #(.MAX_SECTIONS(MAX_SECTIONS), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk, .arst_n, .mem_size(mem_size_q),
		.ld_req_type(req_type), .ld_alloc_size(alloc_size), .ld_free_id(free_id),
		.ctl, .sts, .new_id(nid)
	);

	ffac_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .req_type(type_q), .sts, .new_id(nid),
		.out_ready, .ctl, .idle, .out_valid, .out_status(status), .out_id(section_id)
	);

endmodule

// File: rtl/ffac_datapath.sv
// ----------------------------------------------------------------------------
// ffac_datapath
// Section tables, scan index and arithmetic, driven one command per cycle.
// ----------------------------------------------------------------------------
module ffac_datapath #(
	parameter int MAX_SECTIONS = 16,
	parameter int ADDR_BITS    = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ffac_pkg::SIZE_W-1:0] mem_size,
	input  logic                       ld_req_type,
	input  logic [ffac_pkg::SIZE_W-1:0] ld_alloc_size,
	input  logic [ffac_pkg::ID_W-1:0]   ld_free_id,
	input  ffac_pkg::ctl_t             ctl,
	output ffac_pkg::sts_t             sts,
	output logic [ffac_pkg::ID_W-1:0]   new_id
);
	import ffac_pkg::*;

	localparam int IW = $clog2(MAX_SECTIONS);
	localparam int CW = $clog2(MAX_SECTIONS + 1);

	logic [ADDR_BITS-1:0] f_addr_q [MAX_SECTIONS];
	logic [ADDR_BITS-1:0] f_len_q  [MAX_SECTIONS];
	logic [ID_W-1:0]      f_id_q   [MAX_SECTIONS];
	logic [ADDR_BITS-1:0] u_addr_q [MAX_SECTIONS];
	logic [ADDR_BITS-1:0] u_len_q  [MAX_SECTIONS];
	logic [ID_W-1:0]      u_id_q   [MAX_SECTIONS];
	logic [CW-1:0]        f_cnt_q, u_cnt_q;
	logic [ID_W-1:0]      nid_q;
	logic                 type_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ID_W-1:0]      fid_q;
	logic [CW-1:0]        idx_q;   // scan / shift index
	logic [CW-1:0]        pass_q;  // sort pass counter
	logic [ADDR_BITS-1:0] pos_q;
	logic [ID_W-1:0]      sid_q;

	logic [IW-1:0] ix, ix1;
	logic [ADDR_BITS:0] size_ext, flen_ext;
	logic [ADDR_BITS-1:0] size_a;

	assign ix  = idx_q[IW-1:0];
	assign ix1 = IW'(idx_q + CW'(1));
	assign size_a = ADDR_BITS'(size_q);
	assign size_ext = (ADDR_BITS+1)'(size_q);
	assign flen_ext = {1'b0, f_len_q[ix]};

	always_comb begin
		sts.free_empty = (f_cnt_q == '0);
		sts.free_full  = (f_cnt_q == CW'(MAX_SECTIONS));
		sts.used_full  = (u_cnt_q == CW'(MAX_SECTIONS));
		sts.size_ok    = ({1'b0, size_q} <= {1'b0, mem_size});
		sts.scan_end   = type_q ? (idx_q >= u_cnt_q) : (idx_q >= f_cnt_q);
		sts.hit        = type_q ? (u_id_q[ix] == fid_q) : (flen_ext >= size_ext);
		sts.exact      = (flen_ext == size_ext);
		sts.sort_end   = (pass_q >= u_cnt_q);
		sts.pack_end   = (idx_q >= u_cnt_q);
		sts.shift_end  = type_q ? (idx_q + CW'(1) >= u_cnt_q)
		                        : (idx_q + CW'(1) >= f_cnt_q);
	end

	// id of the section being allocated this cycle, else the latched one
	assign new_id = (ctl.cmd == CMD_ALLOC) ? (sts.exact ? f_id_q[ix] : nid_q) : sid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_cnt_q <= CW'(1);
			u_cnt_q <= '0;
			nid_q   <= ID_W'(1);
			idx_q   <= '0;
			pass_q  <= '0;
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				f_addr_q[i] <= '0;
				f_len_q[i]  <= '0;
				f_id_q[i]   <= '0;
			end
			f_len_q[0] <= ADDR_BITS'(SIZE_W'(4096));
		end else begin
			case (ctl.cmd)
				CMD_LOAD: begin
					type_q <= ld_req_type;
					size_q <= ld_alloc_size;
					fid_q  <= ld_free_id;
					idx_q  <= '0;
					pass_q <= '0;
					pos_q  <= '0;
					sid_q  <= '0;
				end
				CMD_SCAN_STEP: idx_q <= idx_q + CW'(1);
				CMD_SORT_STEP: begin
					// bubble sort of the used table by address: idx walks 0..cnt-2, pass counts
					if (idx_q + CW'(1) < u_cnt_q) begin
						if (u_addr_q[ix] > u_addr_q[ix1]) begin
							u_addr_q[ix] <= u_addr_q[ix1];
							u_len_q[ix]  <= u_len_q[ix1];
							u_id_q[ix]   <= u_id_q[ix1];
							u_addr_q[ix1] <= u_addr_q[ix];
							u_len_q[ix1]  <= u_len_q[ix];
							u_id_q[ix1]   <= u_id_q[ix];
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q  <= '0;
						pass_q <= pass_q + CW'(1);
					end
				end
				CMD_PACK_STEP: begin
					u_addr_q[ix] <= pos_q;
					pos_q <= pos_q + u_len_q[ix];
					idx_q <= idx_q + CW'(1);
				end
				CMD_PACK_DONE: begin
					f_addr_q[0] <= pos_q;
					f_len_q[0]  <= ({1'b0, mem_size} > (SIZE_W+1)'(pos_q))
						? ADDR_BITS'(mem_size - SIZE_W'(pos_q)) : '0;
					f_id_q[0] <= nid_q;
					nid_q     <= nid_q + ID_W'(1);
					f_cnt_q   <= CW'(1);
					idx_q     <= '0;
				end
				CMD_ALLOC: begin
					if (sts.exact) begin
						u_addr_q[u_cnt_q[IW-1:0]] <= f_addr_q[ix];
						u_len_q[u_cnt_q[IW-1:0]]  <= f_len_q[ix];
						u_id_q[u_cnt_q[IW-1:0]]   <= f_id_q[ix];
						sid_q <= f_id_q[ix];
					end else begin
						f_len_q[ix] <= f_len_q[ix] - size_a;
						u_addr_q[u_cnt_q[IW-1:0]] <= f_addr_q[ix] + f_len_q[ix] - size_a;
						u_len_q[u_cnt_q[IW-1:0]]  <= size_a;
						u_id_q[u_cnt_q[IW-1:0]]   <= nid_q;
						sid_q <= nid_q;
						nid_q <= nid_q + ID_W'(1);
					end
					u_cnt_q <= u_cnt_q + CW'(1);
				end
				CMD_FREE: begin
					f_addr_q[f_cnt_q[IW-1:0]] <= u_addr_q[ix];
					f_len_q[f_cnt_q[IW-1:0]]  <= u_len_q[ix];
					f_id_q[f_cnt_q[IW-1:0]]   <= u_id_q[ix];
					f_cnt_q <= f_cnt_q + CW'(1);
				end
				CMD_SHIFT_FREE: begin
					if (idx_q + CW'(1) < f_cnt_q) begin
						f_addr_q[ix] <= f_addr_q[ix1];
						f_len_q[ix]  <= f_len_q[ix1];
						f_id_q[ix]   <= f_id_q[ix1];
						idx_q <= idx_q + CW'(1);
					end else
						f_cnt_q <= f_cnt_q - CW'(1);
				end
				CMD_SHIFT_USED: begin
					if (idx_q + CW'(1) < u_cnt_q) begin
						u_addr_q[ix] <= u_addr_q[ix1];
						u_len_q[ix]  <= u_len_q[ix1];
						u_id_q[ix]   <= u_id_q[ix1];
						idx_q <= idx_q + CW'(1);
					end else
						u_cnt_q <= u_cnt_q - CW'(1);
				end
				default: ;
			endcase
			if (ctl.clr_idx)
				idx_q <= '0;
		end
	end

endmodule

// File: rtl/ffac_ctrl.sv
// ----------------------------------------------------------------------------
// ffac_ctrl
// Request sequencer: scan, compaction, table update and response.
// ----------------------------------------------------------------------------
module ffac_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_fire,
	input  logic                       req_type,
	input  ffac_pkg::sts_t             sts,
	input  logic [ffac_pkg::ID_W-1:0]   new_id,
	input  logic                       out_ready,
	output ffac_pkg::ctl_t             ctl,
	output logic                       idle,
	output logic                       out_valid,
	output logic [ffac_pkg::STAT_W-1:0] out_status,
	output logic [ffac_pkg::ID_W-1:0]   out_id
);
	import ffac_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CHECK  = 11'b00000000010,
		S_SCAN   = 11'b00000000100,
		S_SORT   = 11'b00000001000,
		S_PACK   = 11'b00000010000,
		S_PDONE  = 11'b00000100000,
		S_RESCAN = 11'b00001000000,
		S_ALLOC  = 11'b00010000000,
		S_SHIFT  = 11'b00100000000,
		S_FSCAN  = 11'b01000000000,
		S_USHIFT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   done;
	logic [STAT_W-1:0] st_d;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '{cmd: CMD_NOP, clr_idx: 1'b0};
		done    = 1'b0;
		st_d    = ST_REFUSED;
		case (state_q)
			S_IDLE: if (in_fire) begin
				ctl.cmd = CMD_LOAD;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (req_type == REQ_FREE) state_d = S_FSCAN;
				else if (sts.free_empty || !sts.size_ok || sts.used_full) begin
					done = 1'b1;
					state_d = S_IDLE;
				end else state_d = S_SCAN;
			end
			S_SCAN, S_RESCAN: begin
				if (sts.scan_end) begin
					if (state_q == S_SCAN) begin
						ctl.clr_idx = 1'b1;
						state_d = S_SORT;
					end else begin
						done = 1'b1;
						state_d = S_IDLE;
					end
				end else if (sts.hit) state_d = S_ALLOC;
				else ctl.cmd = CMD_SCAN_STEP;
			end
			S_SORT: begin
				if (sts.sort_end) begin
					ctl.clr_idx = 1'b1;
					state_d = S_PACK;
				end else ctl.cmd = CMD_SORT_STEP;
			end
			S_PACK: begin
				if (sts.pack_end) state_d = S_PDONE;
				else ctl.cmd = CMD_PACK_STEP;
			end
			S_PDONE: begin
				ctl.cmd = CMD_PACK_DONE;
				state_d = S_RESCAN;
			end
			S_ALLOC: begin
				ctl.cmd = CMD_ALLOC;
				state_d = sts.exact ? S_SHIFT : S_IDLE;
				if (!sts.exact) done = 1'b1;
			end
			S_SHIFT: begin
				ctl.cmd = CMD_SHIFT_FREE;
				if (sts.shift_end) begin
					done = 1'b1;
					st_d = ST_DONE;
					state_d = S_IDLE;
				end
			end
			S_FSCAN: begin
				if (sts.scan_end) begin
					done = 1'b1;
					st_d = ST_NOTFOUND;
					state_d = S_IDLE;
				end else if (sts.hit) begin
					if (sts.free_full) begin
						done = 1'b1;
						state_d = S_IDLE;
					end else begin
						ctl.cmd = CMD_FREE;
						state_d = S_USHIFT;
					end
				end else ctl.cmd = CMD_SCAN_STEP;
			end
			S_USHIFT: begin
				ctl.cmd = CMD_SHIFT_USED;
				if (sts.shift_end) begin
					done = 1'b1;
					st_d = ST_DONE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_ALLOC && !sts.exact) st_d = ST_DONE;
	end

	// response register; an item is only loaded when it is empty
	logic resp_sid;
	assign resp_sid = (state_q == S_SHIFT) || (state_q == S_ALLOC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (done) begin
				out_valid  <= 1'b1;
				out_status <= st_d;
				out_id     <= resp_sid ? new_id : '0;
			end
		end
	end

endmodule

// File: rtl/ffac_checker.sv
// ----------------------------------------------------------------------------
// ffac_checker
// Port-level checks of the allocator handshakes and responses.
// ----------------------------------------------------------------------------
module ffac_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ffac_pkg::STAT_W-1:0] status,
	input logic [ffac_pkg::ID_W-1:0]   section_id
);
	import ffac_pkg::*;

	a_stat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DONE || status == ST_REFUSED || status == ST_NOTFOUND))
		else $error("bad status code");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken with response pending");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> section_id == '0)
		else $error("nonzero id on failed request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(status))
		else $error("response dropped");

endmodule

bind first_fit_allocator_with_compaction_unit ffac_checker u_ffac_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status, .section_id
);

// File: tb/first_fit_allocator_with_compaction_unit_test.sv
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit_test
// Drives allocate and free requests into the first-fit allocator under several
// memory sizes and handshake idling patterns. Every response is compared with
// a cycle-free predictor of the free and allocated section tables.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit_test;
	import ffac_pkg::*;

	localparam int NSECT       = 16;
	localparam int SETTLE      = 400;      // worst request: a sort plus scans
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [ID_W-1:0]   sid;
	} resp_t;

	// section table predictor and store of pending responses
	class alloc_scoreboard;
		logic [SIZE_W-1:0] mem_size;
		logic [SIZE_W-1:0] f_addr[NSECT], f_len[NSECT], u_addr[NSECT], u_len[NSECT];
		logic [ID_W-1:0]   f_id[NSECT], u_id[NSECT];
		logic [ID_W-1:0]   next_id;
		int                f_cnt, u_cnt;
		resp_t             pending_q[$];
		int                errors, checked, compactions, allocs_done, frees_done;
		int                refused, not_found;

		function new();
			mem_size = 4096;
			foreach (f_addr[i]) begin
				f_addr[i] = 0; f_len[i] = 0; f_id[i] = 0;
				u_addr[i] = 0; u_len[i] = 0; u_id[i] = 0;
			end
			f_len[0] = 4096;
			f_cnt = 1;
			u_cnt = 0;
			next_id = 1;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// random id among the allocated sections, or a random id if none
		function logic [ID_W-1:0] pick_used();
			if (u_cnt == 0)
				return ID_W'($urandom);
			return u_id[$urandom_range(0, u_cnt - 1)];
		endfunction

		function logic [ID_W-1:0] fresh_id();
			logic [ID_W-1:0] v;
			v = next_id;
			next_id = next_id + 1'b1;
			return v;
		endfunction

		function int first_fit(logic [SIZE_W-1:0] sz);
			for (int i = 0; i < f_cnt; i++)
				if (f_len[i] >= sz)
					return i;
			return -1;
		endfunction

		// stable sort by address, pack from zero, one free section after them
		function void compact();
			logic [SIZE_W-1:0] a, l, pos;
			logic [ID_W-1:0]   d;
			int                j;
			for (int i = 1; i < u_cnt; i++) begin
				a = u_addr[i]; l = u_len[i]; d = u_id[i];
				j = i;
				while (j > 0 && u_addr[j-1] > a) begin
					u_addr[j] = u_addr[j-1]; u_len[j] = u_len[j-1]; u_id[j] = u_id[j-1];
					j--;
				end
				u_addr[j] = a; u_len[j] = l; u_id[j] = d;
			end
			pos = 0;
			for (int i = 0; i < u_cnt; i++) begin
				u_addr[i] = pos;
				pos = pos + u_len[i];
			end
			f_addr[0] = pos;
			f_len[0] = (mem_size > pos) ? mem_size - pos : '0;
			f_id[0] = fresh_id();
			f_cnt = 1;
			compactions++;
		endfunction

		function void note_request(logic rt, logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id);
			resp_t r;
			int    k, fnd;
			r.st = ST_REFUSED;
			r.sid = '0;
			if (rt == REQ_ALLOC) begin
				if (f_cnt > 0 && sz <= mem_size && u_cnt < NSECT) begin
					k = first_fit(sz);
					if (k < 0) begin
						compact();
						k = first_fit(sz);
					end
					if (k >= 0) begin
						if (f_len[k] == sz) begin
							u_addr[u_cnt] = f_addr[k]; u_len[u_cnt] = f_len[k];
							u_id[u_cnt] = f_id[k];
							for (int i = k; i + 1 < f_cnt; i++) begin
								f_addr[i] = f_addr[i+1]; f_len[i] = f_len[i+1];
								f_id[i] = f_id[i+1];
							end
							f_cnt--;
						end else begin
							f_len[k] = f_len[k] - sz;
							u_addr[u_cnt] = f_addr[k] + f_len[k];
							u_len[u_cnt] = sz;
							u_id[u_cnt] = fresh_id();
						end
						r.sid = u_id[u_cnt];
						u_cnt++;
						r.st = ST_DONE;
						allocs_done++;
					end
				end
			end else begin
				fnd = -1;
				for (int i = 0; i < u_cnt; i++)
					if (fnd < 0 && u_id[i] == id)
						fnd = i;
				if (fnd < 0) begin
					r.st = ST_NOTFOUND;
				end else if (f_cnt >= NSECT) begin
					r.st = ST_REFUSED;
				end else begin
					f_addr[f_cnt] = u_addr[fnd]; f_len[f_cnt] = u_len[fnd];
					f_id[f_cnt] = u_id[fnd];
					f_cnt++;
					for (int i = fnd; i + 1 < u_cnt; i++) begin
						u_addr[i] = u_addr[i+1]; u_len[i] = u_len[i+1]; u_id[i] = u_id[i+1];
					end
					u_cnt--;
					r.st = ST_DONE;
					frees_done++;
				end
			end
			if (r.st == ST_REFUSED)
				refused++;
			if (r.st == ST_NOTFOUND)
				not_found++;
			pending_q = {pending_q, r};
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_response(logic [STAT_W-1:0] st, logic [ID_W-1:0] sid);
			resp_t e;
			if (pending_q.size() == 0) begin
				report($sformatf("response st=%0d id=%0d with nothing outstanding", st, sid));
			end else begin
				e = pending_q.pop_front();
				checked++;
				if (st !== e.st)
					report($sformatf("status %0d, predicted %0d", st, e.st));
				if (sid !== e.sid)
					report($sformatf("section_id %0d, predicted %0d", sid, e.sid));
			end
		endtask
	endclass

	logic              clk, arst_n;
	logic              in_valid, in_ready, req_type;
	logic [SIZE_W-1:0] alloc_size, cfg_wdata;
	logic [ID_W-1:0]   free_id, section_id;
	logic              out_valid, out_ready, cfg_we;
	logic [STAT_W-1:0] status;

	alloc_scoreboard sb = new();
	int              stall_pct = 0;    // receiver stall rate of the current phase
	int              hold_req = 0;     // long receiver hold-off asked by the stimulus
	int              cycles = 0;

	first_fit_allocator_with_compaction_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .alloc_size(alloc_size), .free_id(free_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .section_id(section_id),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL first_fit_allocator_with_compaction_unit");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom % 100) >= stall_pct;
			end
		end
	end

	// response monitor, samples pre-edge values
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_response(status, section_id);

	// one request; returns at the edge that took it with valid left high, or when idling drops valid and waits
	task automatic send_request(logic rt, logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id,
			int idle_pct);
		req_type <= rt;
		alloc_size <= sz;
		free_id <= id;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(rt, sz, id);
		if (($urandom % 100) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_alloc(logic [SIZE_W-1:0] sz);
		send_request(REQ_ALLOC, sz, ID_W'($urandom), 0);
	endtask

	task automatic send_free(logic [ID_W-1:0] id);
		send_request(REQ_FREE, SIZE_W'($urandom), id, 0);
	endtask

	// let the block go quiet before touching mem_size
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mem_size(logic [SIZE_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.mem_size = v;
	endtask

	// mostly well-formed traffic: fitting sizes and frees of live ids, some noise
	task automatic run_phase(int n, int idle_pct, int stall);
		int                r, s;
		logic [SIZE_W-1:0] sz;
		logic [SIZE_W-1:0] m;
		stall_pct = stall;
		m = sb.mem_size;
		for (int i = 0; i < n; i++) begin
			r = $urandom % 100;
			s = $urandom % 10;
			if (s < 7)
				sz = SIZE_W'($urandom_range(0, (m / 8 > 1) ? m / 8 : 1));
			else if (s < 9)
				sz = SIZE_W'($urandom_range(0, m));
			else
				sz = SIZE_W'($urandom_range(0, 131071));
			if (r < 50)
				send_request(REQ_ALLOC, sz, ID_W'($urandom), idle_pct);
			else if (r < 88)
				send_request(REQ_FREE, sz, sb.pick_used(), idle_pct);
			else
				send_request(REQ_FREE, sz, ID_W'($urandom), idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ALLOC;
		alloc_size = '0;
		free_id = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero length, oversize, unknown id, exact fit, empty free table
		send_alloc(17'd0);
		send_alloc(17'd4097);
		send_alloc(17'h1FFFF);
		send_free(16'hFFFF);
		send_free(16'h0000);
		send_alloc(17'd4096);
		send_alloc(17'd1);
		send_free(16'h0000);
		send_free(16'h0001);
		// fill the allocated table, refuse one, then free until the free table is full
		for (int i = 0; i < NSECT; i++)
			send_alloc(17'd1);
		send_alloc(17'd1);
		for (int i = 0; i < NSECT; i++)
			send_free(sb.pick_used());
		// a large allocation out of the first free section
		send_alloc(17'd4000);

		// shrink below the total of the allocated sections, then allocate again
		write_mem_size(17'd16);
		send_alloc(17'd16);
		send_alloc(17'd3);

		// random phases over several sizes and idling patterns
		write_mem_size(17'd4096);
		run_phase(300, 0, 0);
		write_mem_size(17'd1);
		run_phase(120, 50, 0);
		write_mem_size(17'd65536);
		run_phase(300, 0, 50);
		write_mem_size(17'd256);
		run_phase(300, 33, 33);

		// long receiver hold-off while requests keep coming
		stall_pct = 0;
		hold_req = 2000;
		run_phase(40, 0, 0);

		write_mem_size(SIZE_W'($urandom_range(1, 65536)));
		run_phase(200, 20, 20);

		drain();
		$display("covered %0d responses: %0d allocations, %0d frees, %0d compactions",
			sb.checked, sb.allocs_done, sb.frees_done, sb.compactions);
		$display("refused %0d, unknown id %0d, mismatches %0d",
			sb.refused, sb.not_found, sb.errors);
		if (sb.errors == 0)
			$display("PASS first_fit_allocator_with_compaction_unit");
		else
			$display("FAIL first_fit_allocator_with_compaction_unit");
		$finish;
	end

endmodule

// File: files.f
rtl/ffac_pkg.sv
rtl/ffac_datapath.sv
rtl/ffac_ctrl.sv
rtl/first_fit_allocator_with_compaction_unit.sv
rtl/ffac_checker.sv
tb/first_fit_allocator_with_compaction_unit_test.sv
